FILE: rtl/mexp_pkg.sv
// Package for the modular exponentiation block: value widths, register
// indexes and shared types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

    // Width of message, exponent, modulus and result.
    localparam int VALUE_WIDTH = 16;
    // Modulus as used by the arithmetic: zero stands for 2**VALUE_WIDTH.
    localparam int MOD_WIDTH   = VALUE_WIDTH + 1;
    // Width of the partial sum inside one multiply step (below 3 * modulus).
    localparam int EXT_WIDTH   = VALUE_WIDTH + 3;
    // Step counter of the shared multiplier.
    localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);
    // Width of the register index on the configuration channel.
    localparam int IDX_WIDTH   = 4;

    typedef logic [VALUE_WIDTH-1:0] val_t;
    typedef logic [MOD_WIDTH-1:0]   mod_t;
    typedef logic [EXT_WIDTH-1:0]   ext_t;
    typedef logic [CNT_WIDTH-1:0]   cnt_t;
    typedef logic [IDX_WIDTH-1:0]   idx_t;

    // Register indexes.
    localparam idx_t REG_EXPONENT = idx_t'(0);
    localparam idx_t REG_MODULUS  = idx_t'(1);

    // Register reset values.
    localparam val_t EXPONENT_RESET = val_t'(1);
    localparam val_t MODULUS_RESET  = val_t'(65535);

    // Effective modulus for a register value of zero.
    localparam mod_t MOD_FULL   = mod_t'(1) << VALUE_WIDTH;
    // Last step of the shared multiplier.
    localparam cnt_t CNT_LAST   = cnt_t'(VALUE_WIDTH - 1);

endpackage : mexp_pkg

`default_nettype wire

FILE: rtl/mexp_if.sv
// Handshake channel interfaces of the modular exponentiation block.
// Depends on mexp_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

// Message channel: one value to be exponentiated per word.
interface mexp_msg_if;
    import mexp_pkg::*;

    logic valid;
    logic ready;
    val_t message;

    modport source (output valid, output message, input ready);
    modport sink   (input valid, input message, output ready);
endinterface : mexp_msg_if

// Result channel: one power_mod value per word.
interface mexp_res_if;
    import mexp_pkg::*;

    logic valid;
    logic ready;
    val_t power_mod;

    modport source (output valid, output power_mod, input ready);
    modport sink   (input valid, input power_mod, output ready);
endinterface : mexp_res_if

// Configuration write channel: register index and write data.
interface mexp_cfg_if;
    import mexp_pkg::*;

    logic valid;
    logic ready;
    idx_t index;
    val_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface : mexp_cfg_if

`default_nettype wire

FILE: rtl/mexp_modmul.sv
// Shared bit-serial modular multiplier: result = (a * b) mod m, one bit of b
// per cycle, most significant first. Depends on mexp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mexp_modmul (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              start,
    input  mexp_pkg::val_t   a,
    input  mexp_pkg::val_t   b,
    input  mexp_pkg::mod_t   m,
    output logic             busy,
    output logic             done,
    output mexp_pkg::val_t   result
);
    import mexp_pkg::*;

    logic busy_reg, busy_next;
    logic done_reg, done_next;
    cnt_t cnt_reg, cnt_next;
    val_t a_reg, a_next;
    val_t b_reg, b_next;
    mod_t m_reg, m_next;
    val_t r_reg, r_next;

    ext_t sum;
    ext_t m1;
    ext_t m2;
    ext_t step;

    // One interleaved step: r = 2r + bit * a, then fold back below m.
    // Since r < m and a < m, the sum stays below 3m.
    always_comb
    begin
        sum  = {2'b00, r_reg, 1'b0} + (b_reg[VALUE_WIDTH-1] ? {3'b000, a_reg} : '0);
        m1   = {2'b00, m_reg};
        m2   = {1'b0, m_reg, 1'b0};
        if (sum >= m2)
        begin
            step = sum - m2;
        end
        else if (sum >= m1)
        begin
            step = sum - m1;
        end
        else
        begin
            step = sum;
        end
    end

    // Sequencing of the steps.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        r_next    = r_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = a;
            b_next    = b;
            m_next    = m;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            r_next   = step[VALUE_WIDTH-1:0];
            b_next   = b_reg << 1;
            cnt_next = cnt_reg + cnt_t'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operands and partial result.
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        m_reg <= m_next;
        r_reg <= r_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = r_reg;

endmodule : mexp_modmul

`default_nettype wire

FILE: rtl/modular_exponentiation_top.sv
// The accepted message is first reduced by the modulus, then each squaring and each
// multiply by a set exponent bit runs on the shared multiplier; a clear bit below the top
// set bit skips its multiply. An exponent of zero goes straight to the result word.
// A new message is taken only in the idle state, once the previous result word has been
// loaded into the output register; the shared bit-serial multiplier sets the message rate.
// Reset: asynchronous, active low; exponent resets to 1, modulus to 65535.
// Top level of the modular exponentiation block. Depends on mexp_pkg,
// the channel interfaces in mexp_if.sv and mexp_modmul.
`timescale 1ns / 1ps
`default_nettype none

module modular_exponentiation_top (
    input  wire        clk,
    input  wire        rst_n,
    mexp_cfg_if.sink   cfg,
    mexp_msg_if.sink   msg,
    mexp_res_if.source res
);
    import mexp_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_ACC    = 3'd2;
    localparam logic [2:0] ST_SQR    = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       issued_reg, issued_next;
    logic       res_valid_reg, res_valid_next;
    val_t       exponent_reg, exponent_next;
    val_t       modulus_reg, modulus_next;
    val_t       exp_reg, exp_next;
    val_t       base_reg, base_next;
    val_t       acc_reg, acc_next;
    val_t       sq_reg, sq_next;
    val_t       res_reg, res_next;

    mod_t m_eff;
    val_t one_mod;
    logic mul_start;
    val_t mul_a;
    val_t mul_b;
    logic mul_busy;
    logic mul_done;
    val_t mul_result;

    // Effective modulus and the value 1 reduced by it.
    always_comb
    begin
        m_eff   = (modulus_reg == '0) ? MOD_FULL : {1'b0, modulus_reg};
        one_mod = (modulus_reg == val_t'(1)) ? '0 : val_t'(1);
    end

    // Configuration registers; writes are always taken.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        exponent_next = exponent_reg;
        modulus_next  = modulus_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_EXPONENT: exponent_next = cfg.data;
                REG_MODULUS:  modulus_next  = cfg.data;
                default:      ;
            endcase
        end
    end

    // Sequencer: reduce the message, then square-and-multiply from the
    // lowest exponent bit upward, stopping once no set bit remains.
    always_comb
    begin
        state_next     = state_reg;
        issued_next    = issued_reg;
        res_valid_next = res_valid_reg;
        exp_next       = exp_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        res_next       = res_reg;
        mul_start      = 1'b0;
        mul_a          = sq_reg;
        mul_b          = sq_reg;

        if (res_valid_reg && res.ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg.valid)
                begin
                    base_next = msg.message;
                    exp_next  = exponent_reg;
                    acc_next  = val_t'(1);
                    state_next = (exponent_reg == '0) ? ST_OUT : ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                mul_a = one_mod;
                mul_b = base_reg;
                if (!issued_reg)
                begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end
                else if (mul_done)
                begin
                    sq_next     = mul_result;
                    issued_next = 1'b0;
                    state_next  = ST_ACC;
                end
            end
            ST_ACC:
            begin
                mul_a = sq_reg;
                mul_b = acc_reg;
                if (!exp_reg[0])
                begin
                    state_next = ST_SQR;
                end
                else if (!issued_reg)
                begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end
                else if (mul_done)
                begin
                    acc_next    = mul_result;
                    issued_next = 1'b0;
                    state_next  = ST_SQR;
                end
            end
            ST_SQR:
            begin
                if ((exp_reg >> 1) == '0)
                begin
                    state_next = ST_OUT;
                end
                else if (!issued_reg)
                begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end
                else if (mul_done)
                begin
                    sq_next     = mul_result;
                    exp_next    = exp_reg >> 1;
                    issued_next = 1'b0;
                    state_next  = ST_ACC;
                end
            end
            ST_OUT:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    res_next       = acc_reg;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
            exponent_reg  <= EXPONENT_RESET;
            modulus_reg   <= MODULUS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            res_valid_reg <= res_valid_next;
            exponent_reg  <= exponent_next;
            modulus_reg   <= modulus_next;
        end
    end

    // Working values and the output word.
    always_ff @(posedge clk)
    begin
        exp_reg  <= exp_next;
        base_reg <= base_next;
        acc_reg  <= acc_next;
        sq_reg   <= sq_next;
        res_reg  <= res_next;
    end

    // Shared modular multiplier.
    mexp_modmul u_modmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .m      (m_eff),
        .busy   (mul_busy),
        .done   (mul_done),
        .result (mul_result)
    );

    // Channel outputs.
    assign msg.ready     = (state_reg == ST_IDLE);
    assign res.valid     = res_valid_reg;
    assign res.power_mod = res_reg;

    // The multiplier only finishes work that the sequencer issued.
    a_done_issued: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> issued_reg)
        else $error("multiplier finished without an issued operation");

    // The multiplier is quiet while the block waits for a message.
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!mul_busy && !mul_done))
        else $error("multiplier active while idle");

    // The running square stays reduced below the modulus.
    a_sq_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC || state_reg == ST_SQR) |-> ({1'b0, sq_reg} < m_eff))
        else $error("square not reduced");

    // An accepted message leaves the idle state at the next edge.
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (msg.valid && msg.ready) |=> (state_reg != ST_IDLE))
        else $error("accepted message not started");

endmodule : modular_exponentiation_top

`default_nettype wire
